// ===== hdl/lss_pkg.sv =====
`timescale 1ns / 1ps

package lss_pkg;

  localparam int DEFAULT_DEPTH = 16;

  localparam int OPCODE_W = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int MDEPTH_W = 4;
  localparam int COUNT_W  = 5;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_SEARCH = 3'd4
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_FINISH
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic    accept;
    status_e status;
    logic    wr_push;
    logic    cnt_dec;
    logic    cnt_clr;
    logic    rd_top;
    logic    rd_next;
    logic    take_rd;
    logic    hit;
    logic    load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic match;
    logic ptr_zero;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/lss_dpath.sv =====
`timescale 1ns / 1ps

module lss_dpath
  import lss_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cmd_t                       cmd_i,
  output sts_t                       sts_o,
  input  logic signed [DATA_W-1:0]   operand_i,
  input  logic                       out_stall_i,
  output logic                       out_valid_o,
  output logic signed [DATA_W-1:0]   read_value_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic                       found_o,
  output logic [MDEPTH_W-1:0]        match_depth_o,
  output logic [COUNT_W-1:0]         entry_count_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;
  logic [DATA_W-1:0] key_q;

  logic [CW-1:0] cnt_q, cnt_d, cnt_m1;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] n_q, n_d;
  logic          rd_en;

  logic [DATA_W-1:0] res_value_q;
  status_e           res_status_q;
  logic              res_found_q;
  logic [AW-1:0]     res_depth_q;

  logic                     out_valid_q;
  logic [DATA_W-1:0]        out_value_q;
  logic [STATUS_W-1:0]      out_status_q;
  logic                     out_found_q;
  logic [MDEPTH_W-1:0]      out_depth_q;
  logic [COUNT_W-1:0]       out_count_q;

  assign cnt_m1 = cnt_q - CW'(1);
  assign rd_en  = cmd_i.rd_top | cmd_i.rd_next;

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.wr_push) begin
      cnt_d = cnt_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_m1;
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    n_d   = n_q;
    if (cmd_i.rd_top) begin
      ptr_d = cnt_m1[AW-1:0];
      n_d   = '0;
    end else if (cmd_i.rd_next) begin
      ptr_d = ptr_q - AW'(1);
      n_d   = n_q + AW'(1);
    end
  end

  // stack memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_push) begin
      mem_q[cnt_q[AW-1:0]] <= operand_i;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[ptr_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    n_q   <= n_d;
    if (cmd_i.accept) begin
      key_q        <= operand_i;
      res_value_q  <= '0;
      res_status_q <= cmd_i.status;
      res_found_q  <= 1'b0;
      res_depth_q  <= '0;
    end
    if (cmd_i.take_rd) begin
      res_value_q <= rd_data_q;
    end
    if (cmd_i.hit) begin
      res_found_q <= 1'b1;
      res_depth_q <= n_q;
    end
    if (cmd_i.load_out) begin
      out_value_q  <= res_value_q;
      out_status_q <= res_status_q;
      out_found_q  <= res_found_q;
      out_depth_q  <= MDEPTH_W'(res_depth_q);
      out_count_q  <= COUNT_W'(cnt_q);
    end
  end

  assign sts_o.full     = (cnt_q == CW'(DEPTH));
  assign sts_o.empty    = (cnt_q == '0);
  assign sts_o.match    = (rd_data_q == key_q);
  assign sts_o.ptr_zero = (ptr_q == '0);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = out_value_q;
  assign status_o      = out_status_q;
  assign found_o       = out_found_q;
  assign match_depth_o = out_depth_q;
  assign entry_count_o = out_count_q;

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("entry count above depth");

  a_push_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_push |-> cnt_q < CW'(DEPTH))
    else $error("push into full stack");

  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_dec |-> cnt_q != '0)
    else $error("pop from empty stack");

  a_scan_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_next |-> ptr_q != '0)
    else $error("search ran past the bottom");

  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || !out_stall_i))
    else $error("result overwrote a pending item");

endmodule

// ===== hdl/lss_ctrl.sv =====
`timescale 1ns / 1ps

module lss_ctrl
  import lss_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [OPCODE_W-1:0] opcode_i,
  input  sts_t                sts_i,
  output cmd_t                cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.status = ST_OK;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_FINISH;
          case (opcode_e'(opcode_i))
            OP_PUSH: begin
              if (sts_i.full) begin
                cmd_o.status = ST_FULL;
              end else begin
                cmd_o.wr_push = 1'b1;
              end
            end
            OP_POP: begin
              if (sts_i.empty) begin
                cmd_o.status = ST_EMPTY;
              end else begin
                cmd_o.rd_top  = 1'b1;
                cmd_o.cnt_dec = 1'b1;
                state_d       = S_READ;
              end
            end
            OP_PEEK: begin
              if (sts_i.empty) begin
                cmd_o.status = ST_EMPTY;
              end else begin
                cmd_o.rd_top = 1'b1;
                state_d      = S_READ;
              end
            end
            OP_CLEAR: begin
              cmd_o.cnt_clr = 1'b1;
            end
            OP_SEARCH: begin
              if (!sts_i.empty) begin
                cmd_o.rd_top = 1'b1;
                state_d      = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        cmd_o.take_rd = 1'b1;
        state_d       = S_FINISH;
      end
      S_SCAN: begin
        if (sts_i.match) begin
          cmd_o.hit = 1'b1;
          state_d   = S_FINISH;
        end else if (sts_i.ptr_zero) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.rd_next = 1'b1;
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/lifo_stack_with_search.sv =====
`timescale 1ns / 1ps

// lifo stack of DEPTH signed 32-bit words with a top-down search, one result
// per item. the stack sits in a memory with one write port and one registered
// read port. push, clear and unused opcodes go from accept straight to the
// finish state, pop and peek of a non-empty stack pass through a read state
// first, and a search scans from the top, reading one entry per cycle until a
// match or the bottom. a new item is taken once the previous result has moved
// into the output register, which holds it until the consumer takes it.
module lifo_stack_with_search
  import lss_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [OPCODE_W-1:0]       opcode_i,
  input  logic signed [DATA_W-1:0]  operand_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [DATA_W-1:0]  read_value_o,
  output logic [STATUS_W-1:0]       status_o,
  output logic                      found_o,
  output logic [MDEPTH_W-1:0]       match_depth_o,
  output logic [COUNT_W-1:0]        entry_count_o
);

  cmd_t cmd;
  sts_t sts;

  lss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .opcode_i   (opcode_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lss_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .operand_i     (operand_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .read_value_o  (read_value_o),
    .status_o      (status_o),
    .found_o       (found_o),
    .match_depth_o (match_depth_o),
    .entry_count_o (entry_count_o)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import lss_pkg::*;

  localparam int STACK_DEPTH = DEFAULT_DEPTH;
  localparam int IDLE_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 600;
  localparam int TAIL_CYCLES = 40;

  localparam logic [OPCODE_W-1:0] OP_RSVD_LO = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_RSVD_HI = 3'd7;

  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [STATUS_W-1:0]      status;
    logic                     found;
    logic [MDEPTH_W-1:0]      match_depth;
    logic [COUNT_W-1:0]       entry_count;
  } stack_result_t;

  typedef struct {
    logic [OPCODE_W-1:0]      op;
    logic signed [DATA_W-1:0] operand;
    bit                       typed;
    stack_result_t            want;
  } stim_row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [OPCODE_W-1:0]      opcode_i = '0;
  logic signed [DATA_W-1:0] operand_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [DATA_W-1:0] read_value_o;
  logic [STATUS_W-1:0]      status_o;
  logic                     found_o;
  logic [MDEPTH_W-1:0]      match_depth_o;
  logic [COUNT_W-1:0]       entry_count_o;

  // shadow stack
  logic signed [DATA_W-1:0] shadow_words [STACK_DEPTH];
  int                       shadow_fill = 0;

  stack_result_t            item_result = '0;
  stack_result_t            pending_results [$];
  stim_row_t                directed_rows [$];
  bit                       error_seen = 1'b0;
  int                       idle_cycles = 0;
  int                       burst_left = 0;
  int                       stall_run = 0;
  int                       stall_mode = 0;

  lifo_stack_with_search #(
    .DEPTH(STACK_DEPTH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .operand_i    (operand_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .found_o      (found_o),
    .match_depth_o(match_depth_o),
    .entry_count_o(entry_count_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic stack_result_t predict_stack(input logic [OPCODE_W-1:0] op,
                                                  input logic signed [DATA_W-1:0] word);
    stack_result_t r;
    r = '0;
    case (op)
      OP_PUSH: begin
        if (shadow_fill >= STACK_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_words[shadow_fill] = word;
          shadow_fill++;
        end
      end
      OP_POP: begin
        if (shadow_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          shadow_fill--;
          r.read_value = shadow_words[shadow_fill];
        end
      end
      OP_PEEK: begin
        if (shadow_fill == 0) r.status = ST_EMPTY;
        else r.read_value = shadow_words[shadow_fill-1];
      end
      OP_CLEAR: shadow_fill = 0;
      OP_SEARCH: begin
        for (int i = 0; i < shadow_fill; i++) begin
          if (!r.found && shadow_words[shadow_fill-1-i] == word) begin
            r.found = 1'b1;
            r.match_depth = MDEPTH_W'(i);
          end
        end
      end
      default: ;
    endcase
    r.entry_count = COUNT_W'(shadow_fill);
    return r;
  endfunction

  function automatic stack_result_t result_of(input logic signed [DATA_W-1:0] rv,
                                              input status_e st, input logic hit,
                                              input int depth, input int cnt);
    stack_result_t r;
    r.read_value = rv;
    r.status = st;
    r.found = hit;
    r.match_depth = MDEPTH_W'(depth);
    r.entry_count = COUNT_W'(cnt);
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_word();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '0;
      3: return -1;
      4, 5: return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_row(input logic [OPCODE_W-1:0] op, input logic signed [DATA_W-1:0] word,
                         input bit typed, input stack_result_t want);
    stim_row_t row;
    row.op = op;
    row.operand = word;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_seen = 1'b1;
    end
  endtask

  // the expectation rides along with the item and is queued when it is accepted
  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic signed [DATA_W-1:0] word,
                           input bit typed, input stack_result_t want);
    stack_result_t pred;
    pred = predict_stack(op, word);
    in_valid_i <= 1'b1;
    opcode_i <= op;
    operand_i <= word;
    item_result <= typed ? want : pred;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic sender_gap();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 10);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 12);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_run = $urandom_range(5, 60);
    end
    stall_run--;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= ~out_stall_i;
    endcase
  end

  always @(posedge clk_i) begin
    stack_result_t want;
    if (out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time,
                 {read_value_o, status_o, found_o, match_depth_o, entry_count_o});
        error_seen = 1'b1;
      end else begin
        want = pending_results.pop_front();
        check_field("read_value", want.read_value, read_value_o);
        check_field("status", DATA_W'(want.status), DATA_W'(status_o));
        check_field("found", DATA_W'(want.found), DATA_W'(found_o));
        check_field("match_depth", DATA_W'(want.match_depth), DATA_W'(match_depth_o));
        check_field("entry_count", DATA_W'(want.entry_count), DATA_W'(entry_count_o));
      end
    end
    if (in_valid_i && !in_stall_o) pending_results.push_back(item_result);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [OPCODE_W-1:0]      op;
    logic signed [DATA_W-1:0] word;
    bit                       grow;
    int                       roll;

    add_row(OP_POP, '0, 1'b1, result_of('0, ST_EMPTY, 1'b0, 0, 0));
    add_row(OP_PEEK, -1, 1'b1, result_of('0, ST_EMPTY, 1'b0, 0, 0));
    add_row(OP_SEARCH, '0, 1'b1, result_of('0, ST_OK, 1'b0, 0, 0));
    add_row(OP_PUSH, WORD_MAX, 1'b1, result_of('0, ST_OK, 1'b0, 0, 1));
    add_row(OP_PUSH, WORD_MIN, 1'b1, result_of('0, ST_OK, 1'b0, 0, 2));
    add_row(OP_PEEK, '0, 1'b1, result_of(WORD_MIN, ST_OK, 1'b0, 0, 2));
    add_row(OP_SEARCH, WORD_MAX, 1'b1, result_of('0, ST_OK, 1'b1, 1, 2));
    add_row(OP_RSVD_LO, -1, 1'b1, result_of('0, ST_OK, 1'b0, 0, 2));
    add_row(OP_RSVD_HI, WORD_MAX, 1'b1, result_of('0, ST_OK, 1'b0, 0, 2));
    // fill up to capacity
    for (int i = 0; i < STACK_DEPTH - 2; i++) begin
      word = (i == 0) ? '0 : (i == 1) ? -1 : (i % 2) ? (32'shaaaa_aaaa ^ i) : (32'sh5555_5555 + i);
      add_row(OP_PUSH, word, 1'b0, '0);
    end
    add_row(OP_PUSH, 1, 1'b1, result_of('0, ST_FULL, 1'b0, 0, STACK_DEPTH));
    add_row(OP_SEARCH, WORD_MAX, 1'b1, result_of('0, ST_OK, 1'b1, STACK_DEPTH - 1, STACK_DEPTH));
    add_row(OP_POP, '0, 1'b0, '0);
    add_row(OP_CLEAR, WORD_MIN, 1'b1, result_of('0, ST_OK, 1'b0, 0, 0));
    add_row(OP_PEEK, '0, 1'b1, result_of('0, ST_EMPTY, 1'b0, 0, 0));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].operand, directed_rows[i].typed,
                directed_rows[i].want);
      sender_gap();
    end

    grow = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) wait_drained();
      if (shadow_fill == 0) grow = 1'b1;
      else if (shadow_fill >= STACK_DEPTH && $urandom_range(0, 3) == 0) grow = 1'b0;
      else if ($urandom_range(0, 63) == 0) grow = ~grow;
      roll = $urandom_range(0, 99);
      if (roll < 1) op = OP_CLEAR;
      else if (roll < 4) op = OPCODE_W'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
      else if (roll < 22) op = OP_SEARCH;
      else if (roll < 30) op = OP_PEEK;
      else if (grow) op = (roll < 90) ? OP_PUSH : OP_POP;
      else op = (roll < 50) ? OP_PUSH : OP_POP;
      if (op == OP_SEARCH && shadow_fill > 0 && $urandom_range(0, 9) < 7)
        word = shadow_words[$urandom_range(0, shadow_fill - 1)];
      else
        word = pick_word();
      send_item(op, word, 1'b0, '0);
      sender_gap();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (!error_seen && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
